@@ rtl/core/btfs_pkg.sv @@
package btfs_pkg;

    localparam int CH_BITS        = 16;
    localparam int POS_BITS       = 14;
    localparam int QUO_BITS       = CH_BITS + 2;
    localparam int DEF_MAX_WIDTH  = 64;
    localparam int DEF_MAX_HEIGHT = 64;
    localparam int DEF_FRAC_BITS  = 8;

    // configuration register indexes and reset values
    localparam logic [1:0] REG_FILTER_MODE   = 2'd0;
    localparam logic [1:0] REG_FILTER_OFFSET = 2'd1;
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd2;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd3;
    localparam logic [2:0] RST_FILTER_MODE   = 3'd0;
    localparam logic [3:0] RST_FILTER_OFFSET = 4'd1;
    localparam logic [6:0] RST_IMAGE_SIZE    = 7'd64;

    typedef struct packed {
        logic                action;
        logic [POS_BITS-1:0] x_pos;
        logic [POS_BITS-1:0] y_pos;
        logic [CH_BITS-1:0]  red_in;
        logic [CH_BITS-1:0]  green_in;
        logic [CH_BITS-1:0]  blue_in;
    } t_in_item;

    typedef struct packed {
        logic [CH_BITS-1:0] red_out;
        logic [CH_BITS-1:0] green_out;
        logic [CH_BITS-1:0] blue_out;
    } t_out_item;

    typedef enum logic [2:0] {
        MODE_BILINEAR, MODE_KAWASE, MODE_DUAL_DOWN,
        MODE_DUAL_UP, MODE_NINE_TAP, MODE_THIRTEEN_TAP
    } t_mode;

    localparam logic ACT_WRITE = 1'b0;

    // tap displacement kinds
    typedef enum logic [2:0] {
        AMT_ZERO, AMT_OFF, AMT_HALF, AMT_UNIT, AMT_HUNIT, AMT_KAWASE
    } t_amt;

    typedef struct packed {
        logic       x_neg;
        t_amt       x_amt;
        logic       y_neg;
        t_amt       y_amt;
        logic [1:0] wt_shift;
        logic       last;
    } t_tap;

    typedef enum logic [2:0] {
        S_IDLE, S_SETUP, S_READ, S_DRAIN, S_ROUND, S_DIV, S_DONE
    } t_state;

    typedef struct packed {
        logic       wr_en;
        logic       start_sample;
        logic       setup;
        logic       rd_en;
        logic [1:0] corner;
        logic       next_tap;
        logic       round;
        logic       div_step;
    } t_cmd;

    typedef struct packed {
        logic last_tap;
        logic div3;
    } t_stat;

    function automatic t_tap mk_tap(logic xn, t_amt xa, logic yn, t_amt ya,
                                    logic [1:0] ws, logic last);
        t_tap t;
        t.x_neg    = xn;
        t.x_amt    = xa;
        t.y_neg    = yn;
        t.y_amt    = ya;
        t.wt_shift = ws;
        t.last     = last;
        return t;
    endfunction

    // 3x3 tent, weights 1 2 1 / 2 4 2 / 1 2 1
    function automatic t_tap nine_tap(logic [3:0] idx);
        t_tap t;
        case (idx)
            4'd0:    t = mk_tap(1'b1, AMT_UNIT, 1'b1, AMT_UNIT, 2'd0, 1'b0);
            4'd1:    t = mk_tap(1'b0, AMT_ZERO, 1'b1, AMT_UNIT, 2'd1, 1'b0);
            4'd2:    t = mk_tap(1'b0, AMT_UNIT, 1'b1, AMT_UNIT, 2'd0, 1'b0);
            4'd3:    t = mk_tap(1'b1, AMT_UNIT, 1'b0, AMT_ZERO, 2'd1, 1'b0);
            4'd4:    t = mk_tap(1'b0, AMT_ZERO, 1'b0, AMT_ZERO, 2'd2, 1'b0);
            4'd5:    t = mk_tap(1'b0, AMT_UNIT, 1'b0, AMT_ZERO, 2'd1, 1'b0);
            4'd6:    t = mk_tap(1'b1, AMT_UNIT, 1'b0, AMT_UNIT, 2'd0, 1'b0);
            4'd7:    t = mk_tap(1'b0, AMT_ZERO, 1'b0, AMT_UNIT, 2'd1, 1'b0);
            default: t = mk_tap(1'b0, AMT_UNIT, 1'b0, AMT_UNIT, 2'd0, 1'b1);
        endcase
        return t;
    endfunction

    function automatic t_tap tap_desc(t_mode mode, logic [3:0] idx);
        t_tap t;
        unique case (mode)
            MODE_KAWASE: begin
                case (idx)
                    4'd0:    t = mk_tap(1'b1, AMT_KAWASE, 1'b0, AMT_KAWASE, 2'd0, 1'b0);
                    4'd1:    t = mk_tap(1'b0, AMT_KAWASE, 1'b0, AMT_KAWASE, 2'd0, 1'b0);
                    4'd2:    t = mk_tap(1'b1, AMT_KAWASE, 1'b1, AMT_KAWASE, 2'd0, 1'b0);
                    default: t = mk_tap(1'b0, AMT_KAWASE, 1'b1, AMT_KAWASE, 2'd0, 1'b1);
                endcase
            end
            MODE_DUAL_DOWN: begin
                case (idx)
                    4'd0:    t = mk_tap(1'b0, AMT_ZERO, 1'b0, AMT_ZERO, 2'd2, 1'b0);
                    4'd1:    t = mk_tap(1'b1, AMT_OFF, 1'b0, AMT_OFF, 2'd0, 1'b0);
                    4'd2:    t = mk_tap(1'b0, AMT_OFF, 1'b0, AMT_OFF, 2'd0, 1'b0);
                    4'd3:    t = mk_tap(1'b1, AMT_OFF, 1'b1, AMT_OFF, 2'd0, 1'b0);
                    default: t = mk_tap(1'b0, AMT_OFF, 1'b1, AMT_OFF, 2'd0, 1'b1);
                endcase
            end
            MODE_DUAL_UP: begin
                case (idx)
                    4'd0:    t = mk_tap(1'b0, AMT_ZERO, 1'b0, AMT_OFF, 2'd0, 1'b0);
                    4'd1:    t = mk_tap(1'b1, AMT_OFF, 1'b0, AMT_ZERO, 2'd0, 1'b0);
                    4'd2:    t = mk_tap(1'b0, AMT_OFF, 1'b0, AMT_ZERO, 2'd0, 1'b0);
                    4'd3:    t = mk_tap(1'b0, AMT_ZERO, 1'b1, AMT_OFF, 2'd0, 1'b0);
                    4'd4:    t = mk_tap(1'b1, AMT_HALF, 1'b0, AMT_HALF, 2'd1, 1'b0);
                    4'd5:    t = mk_tap(1'b0, AMT_HALF, 1'b0, AMT_HALF, 2'd1, 1'b0);
                    4'd6:    t = mk_tap(1'b1, AMT_HALF, 1'b1, AMT_HALF, 2'd1, 1'b0);
                    default: t = mk_tap(1'b0, AMT_HALF, 1'b1, AMT_HALF, 2'd1, 1'b1);
                endcase
            end
            MODE_NINE_TAP: t = nine_tap(idx);
            MODE_THIRTEEN_TAP: begin
                case (idx)
                    4'd0:    t = mk_tap(1'b1, AMT_HUNIT, 1'b1, AMT_HUNIT, 2'd2, 1'b0);
                    4'd1:    t = mk_tap(1'b0, AMT_HUNIT, 1'b1, AMT_HUNIT, 2'd2, 1'b0);
                    4'd2:    t = mk_tap(1'b1, AMT_HUNIT, 1'b0, AMT_HUNIT, 2'd2, 1'b0);
                    4'd3:    t = mk_tap(1'b0, AMT_HUNIT, 1'b0, AMT_HUNIT, 2'd2, 1'b0);
                    default: t = nine_tap(4'(idx - 4'd4));
                endcase
            end
            default: t = mk_tap(1'b0, AMT_ZERO, 1'b0, AMT_ZERO, 2'd0, 1'b1);
        endcase
        return t;
    endfunction

    // weight total is 2^shift, times three for dual up
    function automatic logic [2:0] div_shift(t_mode mode);
        logic [2:0] s;
        unique case (mode)
            MODE_KAWASE:       s = 3'd2;
            MODE_DUAL_DOWN:    s = 3'd3;
            MODE_DUAL_UP:      s = 3'd2;
            MODE_NINE_TAP:     s = 3'd4;
            MODE_THIRTEEN_TAP: s = 3'd5;
            default:           s = 3'd0;
        endcase
        return s;
    endfunction

endpackage

@@ rtl/core/bloom_tap_filter_sampler_top.sv @@
// write beat: taken straight from idle, busy stays low; sample beat: each tap is
// one setup plus four single-port store reads, then drain and round follow, and a
// divide step is added for dual up
// one sample in flight at a time, next beat taken in the cycle after its result;
// the receiver cannot stall, o_valid is one cycle
// synchronous active-low reset clears control and config, the pixel store is not
// cleared and reads as garbage until written
module bloom_tap_filter_sampler_top #(
    parameter int MAX_WIDTH  = btfs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = btfs_pkg::DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = btfs_pkg::DEF_FRAC_BITS
) (
    input  logic                i_clk,
    input  logic                i_rst_n,
    // command side
    input  logic                start,
    output logic                busy,
    input  btfs_pkg::t_in_item  i_item,
    // result side
    output logic                o_valid,
    output btfs_pkg::t_out_item o_result,
    // register write channel
    input  logic                i_cfg_valid,
    output logic                o_cfg_ready,
    input  logic [1:0]          i_cfg_index,
    input  logic [6:0]          i_cfg_data
);
    import btfs_pkg::*;

    logic [2:0] r_cfg_mode;
    logic [3:0] r_cfg_offset;
    logic [6:0] r_cfg_width;
    logic [6:0] r_cfg_height;
    t_mode      mode_n;
    t_cmd       cmd;
    t_stat      stat;

    // registers are to change only between beats, a rule left to the user; writes are always taken
    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg_mode   <= RST_FILTER_MODE;
            r_cfg_offset <= RST_FILTER_OFFSET;
            r_cfg_width  <= RST_IMAGE_SIZE;
            r_cfg_height <= RST_IMAGE_SIZE;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_index)
                REG_FILTER_MODE:   r_cfg_mode   <= i_cfg_data[2:0];
                REG_FILTER_OFFSET: r_cfg_offset <= i_cfg_data[3:0];
                REG_IMAGE_WIDTH:   r_cfg_width  <= i_cfg_data;
                REG_IMAGE_HEIGHT:  r_cfg_height <= i_cfg_data;
                default: ;
            endcase
        end
    end

    // the two spare mode codes fall back to a single bilinear tap
    assign mode_n = (r_cfg_mode > 3'(MODE_THIRTEEN_TAP)) ? MODE_BILINEAR
                                                         : t_mode'(r_cfg_mode);

    // sequencer: setup, four reads per tap, drain, round, optional divide
    btfs_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (start),
        .i_action (i_item.action),
        .i_stat   (stat),
        .o_cmd    (cmd),
        .o_busy   (busy),
        .o_valid  (o_valid)
    );

    // pixel store, tap geometry, multiply-accumulate and rounding
    btfs_datapath #(
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT),
        .FRAC_BITS  (FRAC_BITS)
    ) u_datapath (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_cmd    (cmd),
        .i_item   (i_item),
        .i_mode   (mode_n),
        .i_offset (r_cfg_offset),
        .i_width  (r_cfg_width),
        .i_height (r_cfg_height),
        .o_stat   (stat),
        .o_result (o_result)
    );

endmodule

@@ rtl/core/btfs_ctrl.sv @@
module btfs_ctrl (
    input  logic           i_clk,
    input  logic           i_rst_n,
    input  logic           i_start,
    input  logic           i_action,
    input  btfs_pkg::t_stat i_stat,
    output btfs_pkg::t_cmd  o_cmd,
    output logic           o_busy,
    output logic           o_valid
);
    import btfs_pkg::*;

    t_state r_state, n_state;
    logic [1:0]     r_cnt, n_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
        end
    end

    always_comb begin
        n_state = r_state;
        n_cnt   = r_cnt;
        o_cmd   = '0;
        o_cmd.corner = r_cnt;
        unique case (r_state)
            S_IDLE: begin
                if (i_start) begin
                    if (i_action == ACT_WRITE) begin
                        o_cmd.wr_en = 1'b1;
                    end else begin
                        o_cmd.start_sample = 1'b1;
                        n_state = S_SETUP;
                    end
                end
            end
            S_SETUP: begin
                o_cmd.setup = 1'b1;
                n_cnt   = '0;
                n_state = S_READ;
            end
            S_READ: begin
                o_cmd.rd_en = 1'b1;
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd3) begin
                    if (i_stat.last_tap) begin
                        n_state = S_DRAIN;
                    end else begin
                        o_cmd.next_tap = 1'b1;
                        n_state = S_SETUP;
                    end
                end
            end
            S_DRAIN: begin
                // read data and product stages still in flight
                n_cnt = r_cnt + 2'd1;
                if (r_cnt == 2'd1) begin
                    n_state = S_ROUND;
                end
            end
            S_ROUND: begin
                o_cmd.round = 1'b1;
                n_state = i_stat.div3 ? S_DIV : S_DONE;
            end
            S_DIV: begin
                o_cmd.div_step = 1'b1;
                n_state = S_DONE;
            end
            S_DONE: begin
                n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    assign o_busy  = (r_state != S_IDLE);
    assign o_valid = (r_state == S_DONE);

endmodule

@@ rtl/core/btfs_datapath.sv @@
module btfs_datapath #(
    parameter int MAX_WIDTH  = btfs_pkg::DEF_MAX_WIDTH,
    parameter int MAX_HEIGHT = btfs_pkg::DEF_MAX_HEIGHT,
    parameter int FRAC_BITS  = btfs_pkg::DEF_FRAC_BITS
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  btfs_pkg::t_cmd     i_cmd,
    input  btfs_pkg::t_in_item i_item,
    input  btfs_pkg::t_mode    i_mode,
    input  logic [3:0]         i_offset,
    input  logic [6:0]         i_width,
    input  logic [6:0]         i_height,
    output btfs_pkg::t_stat    o_stat,
    output btfs_pkg::t_out_item o_result
);
    import btfs_pkg::*;

    localparam int F     = FRAC_BITS;
    localparam int MAXD  = (MAX_WIDTH > MAX_HEIGHT) ? MAX_WIDTH : MAX_HEIGHT;
    localparam int DW    = $clog2(MAXD + 1);
    localparam int IW    = $clog2(MAXD);
    localparam int EW    = (DW > 7) ? DW : 7;
    localparam int CW0   = (F + 5 > 15) ? F + 5 : 15;
    localparam int CW    = ((CW0 > DW + F) ? CW0 : DW + F) + 1;
    localparam int DEPTH = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW    = $clog2(DEPTH);
    localparam int XIW   = POS_BITS - F;
    localparam int XCW   = XIW + 11;
    localparam int WXY   = 2 * F + 2;
    localparam int PW    = CH_BITS + WXY;
    localparam int ACCW  = CH_BITS + 2 * F + 6;
    localparam int SHW   = $clog2(2 * F + 6);
    localparam int RECIP_SH = QUO_BITS + 1;
    localparam logic [QUO_BITS-1:0] RECIP3 = QUO_BITS'(((1 << RECIP_SH) + 1) / 3);
    localparam logic [POS_BITS-1:0] FMASK = POS_BITS'((1 << F) - 1);
    localparam logic [F:0] ONE = (F + 1)'(1) << F;

    logic [3*CH_BITS-1:0] mem [DEPTH];

    // sample context
    t_mode               r_mode;
    logic [POS_BITS-1:0] r_x, r_y;
    logic [3:0]          r_off;
    logic [DW-1:0]       r_w, r_h;
    logic [3:0]          r_tap;

    // tap geometry
    logic [IW-1:0] r_x0, r_x1, r_y0, r_y1;
    logic [F:0]    r_wx0, r_wx1, r_wy0, r_wy1;
    logic [1:0]    r_wsh;

    // read and multiply pipeline
    logic                 r_v1, r_v2;
    logic [3*CH_BITS-1:0] r_rd;
    logic [WXY-1:0]       r_wxy;
    logic [1:0]           r_wsh1, r_wsh2;
    logic [PW-1:0]        r_prod [3];
    logic [ACCW-1:0]      r_acc  [3];
    logic [QUO_BITS-1:0]  r_quo  [3];

    t_tap                  desc;
    logic [POS_BITS-1:0]   bx, by;
    logic signed [CW-1:0]  cx, cy;
    logic [IW-1:0]         gx0, gx1, gy0, gy1;
    logic [F:0]            gwx0, gwx1, gwy0, gwy1;
    logic [DW-1:0]         w_eff, h_eff;
    logic [XIW-1:0]        wxi, wyi;
    logic                  wr_ok;
    logic [AW-1:0]         wr_addr, rd_addr, mem_addr;
    logic [IW-1:0]         sel_x, sel_y;
    logic [WXY-1:0]        wxy;
    logic [CH_BITS-1:0]    rd_ch [3];
    logic [SHW-1:0]        sh_total;
    logic [ACCW-1:0]       half_v;
    logic [ACCW-1:0]       rsum [3];
    logic [2*QUO_BITS-1:0] quo3 [3];

    function automatic logic [CW-1:0] amt_val(t_amt a, logic [3:0] off);
        logic [CW-1:0] v;
        case (a)
            AMT_OFF:    v = CW'(off) << F;
            AMT_HALF:   v = CW'(off) << (F - 1);
            AMT_UNIT:   v = CW'(1) << F;
            AMT_HUNIT:  v = CW'(1) << (F - 1);
            AMT_KAWASE: v = (CW'(off) << F) + (CW'(1) << (F - 1));
            default:    v = '0;
        endcase
        return v;
    endfunction

    // clamp one axis: outside takes the edge pixel, inside lerps
    function automatic void geom(input logic signed [CW-1:0] c, input logic [DW-1:0] dim,
                                 output logic [IW-1:0] i0, output logic [IW-1:0] i1,
                                 output logic [F:0] w0, output logic [F:0] w1);
        logic [CW-1:0] lim;
        logic [IW-1:0] last_i;
        logic [IW-1:0] ip;
        logic [F-1:0]  fr;
        lim    = CW'(dim - 1'b1) << F;
        last_i = IW'(dim - 1'b1);
        ip     = c[F +: IW];
        fr     = c[F-1:0];
        if (c[CW-1]) begin
            i0 = '0;
            i1 = '0;
            w0 = ONE;
            w1 = '0;
        end else if (c > lim) begin
            i0 = last_i;
            i1 = last_i;
            w0 = ONE;
            w1 = '0;
        end else begin
            i0 = ip;
            i1 = (ip < last_i) ? ip + 1'b1 : last_i;
            w0 = ONE - (F + 1)'(fr);
            w1 = (F + 1)'(fr);
        end
    endfunction

    always_comb begin
        if (i_width == '0) begin
            w_eff = DW'(1);
        end else if (EW'(i_width) > EW'(MAX_WIDTH)) begin
            w_eff = DW'(MAX_WIDTH);
        end else begin
            w_eff = DW'(i_width);
        end
        if (i_height == '0) begin
            h_eff = DW'(1);
        end else if (EW'(i_height) > EW'(MAX_HEIGHT)) begin
            h_eff = DW'(MAX_HEIGHT);
        end else begin
            h_eff = DW'(i_height);
        end
    end

    // tap center
    always_comb begin
        desc = tap_desc(r_mode, r_tap);
        bx   = (r_mode == MODE_KAWASE) ? (r_x & ~FMASK) : r_x;
        by   = (r_mode == MODE_KAWASE) ? (r_y & ~FMASK) : r_y;
        cx   = desc.x_neg ? CW'(bx) - amt_val(desc.x_amt, r_off)
                          : CW'(bx) + amt_val(desc.x_amt, r_off);
        cy   = desc.y_neg ? CW'(by) - amt_val(desc.y_amt, r_off)
                          : CW'(by) + amt_val(desc.y_amt, r_off);
        geom(cx, r_w, gx0, gx1, gwx0, gwx1);
        geom(cy, r_h, gy0, gy1, gwy0, gwy1);
    end

    assign o_stat.last_tap = desc.last;
    assign o_stat.div3     = (r_mode == MODE_DUAL_UP);

    always_ff @(posedge i_clk) begin
        if (i_cmd.start_sample) begin
            r_mode <= i_mode;
            r_x    <= i_item.x_pos;
            r_y    <= i_item.y_pos;
            r_off  <= i_offset;
            r_w    <= w_eff;
            r_h    <= h_eff;
            r_tap  <= '0;
        end else if (i_cmd.next_tap) begin
            r_tap  <= r_tap + 4'd1;
        end
        if (i_cmd.setup) begin
            r_x0  <= gx0;
            r_x1  <= gx1;
            r_y0  <= gy0;
            r_y1  <= gy1;
            r_wx0 <= gwx0;
            r_wx1 <= gwx1;
            r_wy0 <= gwy0;
            r_wy1 <= gwy1;
            r_wsh <= desc.wt_shift;
        end
    end

    // write and read addresses and corner weight, writes outside the store are dropped
    always_comb begin
        wxi     = i_item.x_pos[POS_BITS-1:F];
        wyi     = i_item.y_pos[POS_BITS-1:F];
        wr_ok   = (XCW'(wxi) < XCW'(MAX_WIDTH)) && (XCW'(wyi) < XCW'(MAX_HEIGHT));
        wr_addr = AW'(wyi) * AW'(MAX_WIDTH) + AW'(wxi);
        sel_x   = i_cmd.corner[0] ? r_x1 : r_x0;
        sel_y   = i_cmd.corner[1] ? r_y1 : r_y0;
        rd_addr = AW'(sel_y) * AW'(MAX_WIDTH) + AW'(sel_x);
        mem_addr = i_cmd.wr_en ? wr_addr : rd_addr;
        wxy     = WXY'(i_cmd.corner[0] ? r_wx1 : r_wx0) *
                  WXY'(i_cmd.corner[1] ? r_wy1 : r_wy0);
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.wr_en && wr_ok) begin
            mem[mem_addr] <= {i_item.red_in, i_item.green_in, i_item.blue_in};
        end
        if (i_cmd.rd_en) begin
            r_rd <= mem[mem_addr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_cmd.rd_en;
            r_v2 <= r_v1;
        end
    end

    assign rd_ch[0] = r_rd[3*CH_BITS-1:2*CH_BITS];
    assign rd_ch[1] = r_rd[2*CH_BITS-1:CH_BITS];
    assign rd_ch[2] = r_rd[CH_BITS-1:0];

    // final rounding: add half the divisor, drop the power of two
    always_comb begin
        sh_total = SHW'(2 * F) + SHW'(div_shift(r_mode));
        half_v   = (o_stat.div3 ? ACCW'(3) : ACCW'(1)) << (sh_total - 1'b1);
        for (int c = 0; c < 3; c++) begin
            rsum[c] = (r_acc[c] + half_v) >> sh_total;
            // divide by three as a reciprocal multiply, exact below 2^19
            quo3[c] = (2*QUO_BITS)'(r_quo[c]) * (2*QUO_BITS)'(RECIP3);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.rd_en) begin
            r_wxy  <= wxy;
            r_wsh1 <= r_wsh;
        end
        r_wsh2 <= r_wsh1;
        for (int c = 0; c < 3; c++) begin
            r_prod[c] <= PW'(rd_ch[c]) * PW'(r_wxy);
            if (i_cmd.start_sample) begin
                r_acc[c] <= '0;
            end else if (r_v2) begin
                r_acc[c] <= r_acc[c] + (ACCW'(r_prod[c]) << r_wsh2);
            end
            if (i_cmd.round) begin
                r_quo[c] <= rsum[c][QUO_BITS-1:0];
            end else if (i_cmd.div_step) begin
                r_quo[c] <= QUO_BITS'(quo3[c][RECIP_SH +: CH_BITS]);
            end
        end
    end

    assign o_result.red_out   = r_quo[0][CH_BITS-1:0];
    assign o_result.green_out = r_quo[1][CH_BITS-1:0];
    assign o_result.blue_out  = r_quo[2][CH_BITS-1:0];

endmodule
